### hw/rtl/bgl_pkg.sv
`default_nettype none

package bgl_pkg;

  // Command codes of an input word
  typedef enum logic {
    CMD_START = 1'b0,
    CMD_STEP  = 1'b1
  } cmd_t;

endpackage

`default_nettype wire

### hw/rtl/bgl_if.sv
`default_nettype none

interface bgl_in_if #(
  parameter int COORD_BITS   = 12,
  parameter int CHANNEL_BITS = 8
);
  logic                    valid;
  logic                    ready;
  logic                    cmd;
  logic [COORD_BITS-1:0]   start_x;
  logic [COORD_BITS-1:0]   start_y;
  logic [COORD_BITS-1:0]   end_x;
  logic [COORD_BITS-1:0]   end_y;
  logic [CHANNEL_BITS-1:0] start_red;
  logic [CHANNEL_BITS-1:0] start_green;
  logic [CHANNEL_BITS-1:0] start_blue;
  logic [CHANNEL_BITS-1:0] end_red;
  logic [CHANNEL_BITS-1:0] end_green;
  logic [CHANNEL_BITS-1:0] end_blue;

  modport source (
    output valid, cmd, start_x, start_y, end_x, end_y,
           start_red, start_green, start_blue, end_red, end_green, end_blue,
    input  ready
  );
  modport sink (
    input  valid, cmd, start_x, start_y, end_x, end_y,
           start_red, start_green, start_blue, end_red, end_green, end_blue,
    output ready
  );
endinterface

interface bgl_out_if #(
  parameter int COORD_BITS   = 12,
  parameter int CHANNEL_BITS = 8
);
  logic                    valid;
  logic                    ready;
  logic                    pixel_valid;
  logic [COORD_BITS-1:0]   pixel_x;
  logic [COORD_BITS-1:0]   pixel_y;
  logic [CHANNEL_BITS-1:0] pixel_red;
  logic [CHANNEL_BITS-1:0] pixel_green;
  logic [CHANNEL_BITS-1:0] pixel_blue;
  logic                    last_pixel;

  modport source (
    output valid, pixel_valid, pixel_x, pixel_y, pixel_red, pixel_green,
           pixel_blue, last_pixel,
    input  ready
  );
  modport sink (
    input  valid, pixel_valid, pixel_x, pixel_y, pixel_red, pixel_green,
           pixel_blue, last_pixel,
    output ready
  );
endinterface

`default_nettype wire

### hw/rtl/bgl_front.sv
`default_nettype none

module bgl_front #(
  parameter int COORD_BITS   = 12,
  parameter int CHANNEL_BITS = 8,
  parameter int WORD_BITS    = 7 + 4 * COORD_BITS + 6 * CHANNEL_BITS
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  bgl_in_if.sink                    in_ch,
  output logic                      word_valid,
  input  wire logic                 word_ready,
  output logic [WORD_BITS-1:0]      word
);

  localparam int CB = COORD_BITS;
  localparam int VB = CHANNEL_BITS;

  logic                 x_neg, y_neg, major_x;
  logic [CB-1:0]        dx_abs, dy_abs, n_len, minor_len;
  logic [2:0]           c_neg;
  logic [2:0][VB-1:0]   c_a, c_b, c_mag;
  logic                 is_start;

  assign in_ch.ready = !word_valid || word_ready;

  always_comb begin
    is_start  = (in_ch.cmd == bgl_pkg::CMD_START);
    x_neg     = in_ch.end_x < in_ch.start_x;
    y_neg     = in_ch.end_y < in_ch.start_y;
    dx_abs    = x_neg ? in_ch.start_x - in_ch.end_x : in_ch.end_x - in_ch.start_x;
    dy_abs    = y_neg ? in_ch.start_y - in_ch.end_y : in_ch.end_y - in_ch.start_y;
    major_x   = dy_abs <= dx_abs;
    n_len     = major_x ? dx_abs : dy_abs;
    minor_len = major_x ? dy_abs : dx_abs;
    c_a = {in_ch.start_red, in_ch.start_green, in_ch.start_blue};
    c_b = {in_ch.end_red, in_ch.end_green, in_ch.end_blue};
    for (int j = 0; j < 3; j++) begin
      c_neg[j] = c_b[j] < c_a[j];
      c_mag[j] = c_neg[j] ? c_a[j] - c_b[j] : c_b[j] - c_a[j];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_valid <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      word_valid <= 1'b1;
    end else if (word_ready) begin
      word_valid <= 1'b0;
    end
  end

  // Step words carry the geometry fields too (major_x cleared); only their command is used downstream
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      word <= {in_ch.cmd, in_ch.start_x, in_ch.start_y, x_neg, y_neg,
               major_x && is_start, n_len, minor_len, c_a, c_neg, c_mag};
    end
  end

endmodule

`default_nettype wire

### hw/rtl/bgl_queue.sv
`default_nettype none

module bgl_queue #(
  parameter int WORD_BITS = 103
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [WORD_BITS-1:0] in_word,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [WORD_BITS-1:0]      out_word
);

  localparam int DEPTH = 2;

  logic [WORD_BITS-1:0] mem [DEPTH];
  logic                 wr_ptr, rd_ptr;
  logic [1:0]           count;
  logic                 push, pop;

  assign in_ready  = count != 2'(DEPTH);
  assign out_valid = count != 2'd0;
  assign out_word  = mem[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= in_word;
  end

endmodule

`default_nettype wire

### hw/rtl/bgl_div.sv
`default_nettype none

module bgl_div #(
  parameter int COORD_BITS   = 12,
  parameter int CHANNEL_BITS = 8
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    start,
  input  wire logic [CHANNEL_BITS-1:0] dividend,
  input  wire logic [COORD_BITS-1:0]   divisor,
  output logic                         busy,
  output logic [CHANNEL_BITS-1:0]      quotient,
  output logic [COORD_BITS-1:0]        remainder
);

  localparam int CB = COORD_BITS;
  localparam int VB = CHANNEL_BITS;
  localparam int CW = (VB > 1) ? $clog2(VB) : 1;

  logic [CW-1:0] cnt;
  logic [VB-1:0] dv;
  logic [CB-1:0] rem;
  logic [CB:0]   shifted;
  logic [CB-1:0] dsr;
  logic          ge;

  assign quotient  = dv;
  assign remainder = rem;

  always_comb begin
    shifted = {rem, dv[VB-1]};
    ge      = shifted >= {1'b0, dsr};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && cnt == '0) begin
      busy <= 1'b0;
    end
  end

  // One quotient bit a cycle while busy, restoring form; quotient bits shift into dv
  always_ff @(posedge clk) begin
    if (start) begin
      dv  <= dividend;
      rem <= '0;
      dsr <= divisor;
      cnt <= CW'(VB - 1);
    end else if (busy) begin
      rem <= ge ? CB'(shifted - {1'b0, dsr}) : shifted[CB-1:0];
      dv  <= (dv << 1) | VB'(ge);
      cnt <= cnt - CW'(1);
    end
  end

endmodule

`default_nettype wire

### hw/rtl/bgl_back.sv
`default_nettype none

module bgl_back #(
  parameter int COORD_BITS   = 12,
  parameter int CHANNEL_BITS = 8,
  parameter int WORD_BITS    = 7 + 4 * COORD_BITS + 6 * CHANNEL_BITS
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 word_valid,
  output logic                      word_ready,
  input  wire logic [WORD_BITS-1:0] word,
  bgl_out_if.source                 out_ch
);

  localparam int CB = COORD_BITS;
  localparam int VB = CHANNEL_BITS;
  localparam int EW = CB + 3;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_RUN  = 3'b100
  } state_t;

  state_t state, state_next;

  // Unpacked command word
  logic               w_cmd, w_xneg, w_yneg, w_majx;
  logic [CB-1:0]      w_ax, w_ay, w_n, w_minor;
  logic [2:0][VB-1:0] w_base, w_mag;
  logic [2:0]         w_dneg;

  // Line state
  logic [CB-1:0]      cur_x, cur_y, n_len, minor_len, steps_left;
  logic signed [EW-1:0] err;
  logic               major_x, x_neg, y_neg;
  logic [2:0][VB-1:0] base, qacc;
  logic [2:0][CB-1:0] racc;
  logic [2:0]         dneg;

  // Divider lanes
  logic [2:0]         dv_busy;
  logic [2:0][VB-1:0] dv_quo;
  logic [2:0][CB-1:0] dv_rem;
  logic               dv_start;

  // Next-step values
  logic               err_pos, mv_x, mv_y, take, is_start, last_step;
  logic signed [EW-1:0] err_next, err_init;
  logic [CB-1:0]      x_next, y_next, steps_left_next;
  logic [2:0][VB-1:0] qacc_next, color_next;
  logic [2:0][CB-1:0] racc_next;
  logic [CB:0]        rsum;
  logic               wrap;

  assign {w_cmd, w_ax, w_ay, w_xneg, w_yneg, w_majx, w_n, w_minor,
          w_base, w_dneg, w_mag} = word;

  assign word_ready = (state != ST_DIV) && (!out_ch.valid || out_ch.ready);
  assign take       = word_valid && word_ready;
  assign is_start   = (w_cmd == bgl_pkg::CMD_START);
  assign dv_start   = take && is_start && (w_n != '0);

  for (genvar j = 0; j < 3; j++) begin : g_lane
    bgl_div #(
      .COORD_BITS   (CB),
      .CHANNEL_BITS (VB)
    ) u_div (
      .clk       (clk),
      .rst       (rst),
      .start     (dv_start),
      .dividend  (w_mag[j]),
      .divisor   (w_n),
      .busy      (dv_busy[j]),
      .quotient  (dv_quo[j]),
      .remainder (dv_rem[j])
    );
  end

  always_comb begin
    rsum = '0;
    wrap = 1'b0;
    err_pos  = !err[EW-1] && (err != '0);
    err_next = err_pos ? err + ((EW'(minor_len) - EW'(n_len)) <<< 1)
                       : err + (EW'(minor_len) <<< 1);
    err_init = (EW'(w_minor) <<< 1) - EW'(w_n);
    mv_x     = major_x || err_pos;
    mv_y     = !major_x || err_pos;
    x_next   = mv_x ? cur_x + (x_neg ? {CB{1'b1}} : CB'(1)) : cur_x;
    y_next   = mv_y ? cur_y + (y_neg ? {CB{1'b1}} : CB'(1)) : cur_y;
    steps_left_next = steps_left - CB'(1);
    last_step = steps_left_next == '0;
    // Quotient and remainder of |delta| * k / n, advanced by |delta| / n per step
    for (int j = 0; j < 3; j++) begin
      rsum = {1'b0, racc[j]} + {1'b0, dv_rem[j]};
      wrap = rsum >= {1'b0, n_len};
      racc_next[j]  = wrap ? CB'(rsum - {1'b0, n_len}) : rsum[CB-1:0];
      qacc_next[j]  = qacc[j] + dv_quo[j] + VB'(wrap);
      color_next[j] = dneg[j] ? base[j] - qacc_next[j] : base[j] + qacc_next[j];
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (take && is_start && w_n != '0) state_next = ST_DIV;
      end
      ST_DIV: begin
        if (dv_busy == '0) state_next = ST_RUN;
      end
      ST_RUN: begin
        if (take && is_start) begin
          state_next = (w_n != '0) ? ST_DIV : ST_IDLE;
        end else if (take && last_step) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      out_ch.valid <= 1'b0;
    end else begin
      state <= state_next;
      if (take) begin
        out_ch.valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_ch.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && is_start) begin
      cur_x      <= w_ax;
      cur_y      <= w_ay;
      err        <= err_init;
      n_len      <= w_n;
      minor_len  <= w_minor;
      steps_left <= w_n;
      major_x    <= w_majx;
      x_neg      <= w_xneg;
      y_neg      <= w_yneg;
      base       <= w_base;
      dneg       <= w_dneg;
      qacc       <= '0;
      racc       <= '0;
      out_ch.pixel_valid <= 1'b1;
      out_ch.pixel_x     <= w_ax;
      out_ch.pixel_y     <= w_ay;
      out_ch.pixel_red   <= w_base[2];
      out_ch.pixel_green <= w_base[1];
      out_ch.pixel_blue  <= w_base[0];
      out_ch.last_pixel  <= w_n == '0;
    end else if (take && state == ST_RUN) begin
      cur_x      <= x_next;
      cur_y      <= y_next;
      err        <= err_next;
      steps_left <= steps_left_next;
      qacc       <= qacc_next;
      racc       <= racc_next;
      out_ch.pixel_valid <= 1'b1;
      out_ch.pixel_x     <= x_next;
      out_ch.pixel_y     <= y_next;
      out_ch.pixel_red   <= color_next[2];
      out_ch.pixel_green <= color_next[1];
      out_ch.pixel_blue  <= color_next[0];
      out_ch.last_pixel  <= last_step;
    end else if (take) begin
      // Step with no line in progress: empty word
      out_ch.pixel_valid <= 1'b0;
      out_ch.pixel_x     <= '0;
      out_ch.pixel_y     <= '0;
      out_ch.pixel_red   <= '0;
      out_ch.pixel_green <= '0;
      out_ch.pixel_blue  <= '0;
      out_ch.last_pixel  <= 1'b0;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/bresenham_gradient_line.sv
`default_nettype none

// Channel   Dir  Word
// in_ch     in   cmd, endpoints, endpoint colors
// out_ch    out  pixel_valid, pixel x/y, interpolated color, last_pixel
//
// A start word for a line of nonzero length holds the stepping engine while
// three bit-serial dividers form |delta| / n; its first pixel leaves at once.
// Step words are then taken in turn, one pixel word each, while the output
// does not stall. Decode, queue and engine each register a word on its way.
// Synchronous reset clears control state only; no clearing pass is needed.
// A two-word queue between decode and the engine absorbs output stalls.

module bresenham_gradient_line #(
  parameter int COORD_BITS   = 12,
  parameter int CHANNEL_BITS = 8
) (
  input  wire logic clk,
  input  wire logic rst,
  bgl_in_if.sink    in_ch,
  bgl_out_if.source out_ch
);

  localparam int WORD_BITS = 7 + 4 * COORD_BITS + 6 * CHANNEL_BITS;

  logic                 f_valid, f_ready, q_valid, q_ready;
  logic [WORD_BITS-1:0] f_word, q_word;

  bgl_front #(
    .COORD_BITS   (COORD_BITS),
    .CHANNEL_BITS (CHANNEL_BITS),
    .WORD_BITS    (WORD_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_ch      (in_ch),
    .word_valid (f_valid),
    .word_ready (f_ready),
    .word       (f_word)
  );

  bgl_queue #(
    .WORD_BITS (WORD_BITS)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_word   (f_word),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_word  (q_word)
  );

  bgl_back #(
    .COORD_BITS   (COORD_BITS),
    .CHANNEL_BITS (CHANNEL_BITS),
    .WORD_BITS    (WORD_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .word_valid (q_valid),
    .word_ready (q_ready),
    .word       (q_word),
    .out_ch     (out_ch)
  );

endmodule

`default_nettype wire
